>>> sv/firq_pkg.sv
// ----------------------------------------------------------------------------
// firq_pkg: shared types and constants of the Q15 FIR filter
// Widths of samples, coefficients, products and the accumulator, register
// index codes and the control bundle handed between pipeline stages.
// ----------------------------------------------------------------------------
`default_nettype none

package firq_pkg;

	// Tap chain geometry
	localparam int MAX_TAPS      = 16;
	localparam int TAP_W         = 5;
	localparam int FILL_W        = 4;
	localparam int COEF_IDX_W    = 4;

	// Datapath widths
	localparam int SAMPLE_W      = 16;
	localparam int COEF_W        = 16;
	localparam int PROD_W        = SAMPLE_W + COEF_W;
	localparam int ACC_W         = PROD_W + $clog2(MAX_TAPS);
	localparam int Q_SHIFT       = 15;
	localparam int QUOT_W        = ACC_W - Q_SHIFT;

	// Configuration port
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_ADDR_W    = 6;
	localparam int REG_IDX_W     = 3;
	localparam int COEF_WORDS    = 4;
	localparam int COEF_PER_WORD = 4;

	localparam logic [TAP_W-1:0]  TAP_RESET = TAP_W'(1);
	localparam logic [FILL_W-1:0] FILL_MAX  = FILL_W'(MAX_TAPS - 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [COEF_W-1:0]   coef_t;
	typedef logic signed [PROD_W-1:0]   prod_t;
	typedef logic signed [ACC_W-1:0]    acc_t;
	typedef logic signed [QUOT_W-1:0]   quot_t;

	localparam sample_t SAT_MAX = sample_t'(16'sh7fff);
	localparam sample_t SAT_MIN = sample_t'(16'sh8000);

	// Register map, one 64-bit register every 8 bytes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_NTAPS  = 3'd0,
		REG_COEF_0 = 3'd1,
		REG_COEF_1 = 3'd2,
		REG_COEF_2 = 3'd3,
		REG_COEF_3 = 3'd4
	} reg_idx_t;

	// Pipeline control handed to the adder tree
	typedef struct packed {
		logic en;
		logic vld;
	} stage_ctl_t;

endpackage

`default_nettype wire

>>> sv/firq_tap_cell.sv
// ----------------------------------------------------------------------------
// firq_tap_cell: one cell of the tap chain
// Holds one sample of the delay line, passes it to the next cell on each
// transfer and registers the product of the incoming sample and its tap.
// ----------------------------------------------------------------------------
`default_nettype none

module firq_tap_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              shift_en,
	input  firq_pkg::sample_t x_in,
	input  firq_pkg::coef_t   coef,
	output firq_pkg::sample_t x_q,
	output firq_pkg::prod_t   prod_s1
);

	import firq_pkg::*;

	// Advance the delay line by one sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0;
		end else if (shift_en) begin
			x_q <= x_in;
		end
	end

	// Multiply the sample seen at this tap
	always_ff @(posedge clk) begin
		if (shift_en) begin
			prod_s1 <= prod_t'(x_in) * prod_t'(coef);
		end
	end

endmodule

`default_nettype wire

>>> sv/firq_sum_tree.sv
// ----------------------------------------------------------------------------
// firq_sum_tree: registered adder tree over the tap products
// Four levels of pairwise adds, one register level each, at full
// accumulator width so the sum stays exact.
// ----------------------------------------------------------------------------
`default_nettype none

module firq_sum_tree (
	input  logic                 clk,
	input  logic                 arst_n,
	input  firq_pkg::stage_ctl_t ctl_s1,
	input  firq_pkg::prod_t      prod_s1 [firq_pkg::MAX_TAPS],
	output firq_pkg::acc_t       sum_s5,
	output logic                 vld_s5
);

	import firq_pkg::*;

	acc_t lvl_s2 [MAX_TAPS/2];
	acc_t lvl_s3 [MAX_TAPS/4];
	acc_t lvl_s4 [MAX_TAPS/8];
	logic vld_s2;
	logic vld_s3;
	logic vld_s4;

	// Move valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (ctl_s1.en) begin
			vld_s2 <= ctl_s1.vld;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	// Reduce pairs level by level
	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			for (int i = 0; i < MAX_TAPS/2; i++) begin
				lvl_s2[i] <= acc_t'(prod_s1[2*i]) + acc_t'(prod_s1[2*i+1]);
			end
			for (int i = 0; i < MAX_TAPS/4; i++) begin
				lvl_s3[i] <= lvl_s2[2*i] + lvl_s2[2*i+1];
			end
			for (int i = 0; i < MAX_TAPS/8; i++) begin
				lvl_s4[i] <= lvl_s3[2*i] + lvl_s3[2*i+1];
			end
			sum_s5 <= lvl_s4[0] + lvl_s4[1];
		end
	end

endmodule

`default_nettype wire

>>> sv/fir_filter_q15.sv
// ----------------------------------------------------------------------------
// fir_filter_q15: streaming saturating Q15 FIR filter
// Direct-form FIR on a chain of tap cells with a registered adder tree,
// arithmetic shift by 15 and saturation to 16 bits.
// ----------------------------------------------------------------------------
// The filter takes one signed Q15 sample per clock while in_ready is high
// and, once the current block has supplied as many samples as the tap
// count, gives one saturated result per sample: the products register in
// the tap cells at the sample transfer, then pass the registered levels of
// the adder tree, and shift and saturation feed the output register.
// Throughput is one sample per cycle, since every stage takes new data on
// each cycle; when a result waits at the output the whole pipeline holds
// and in_ready drops. A sample with block_start high begins a new window.
// Tap counts of 0 act as 1 and values above 16 act as 16. Registers sit at
// byte address 8*i: the tap count, then four 64-bit words of coefficients,
// four per word, lowest index in the low bits. Write configuration only
// while no samples are in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module fir_filter_q15 (
	input  logic                                clk,
	input  logic                                arst_n,
	// sample channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  firq_pkg::sample_t                   sample_in,
	input  logic                                block_start,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output firq_pkg::sample_t                   filtered,
	output logic                                clipped,
	// configuration port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [firq_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [firq_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [firq_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready
);

	import firq_pkg::*;

	logic [TAP_W-1:0]                           tap_q;
	logic [COEF_WORDS-1:0][CFG_DATA_W-1:0]      coef_q;
	logic [FILL_W-1:0]                          fill_q;
	reg_idx_t                                   reg_idx;
	logic                                       cfg_wr;

	logic [TAP_W-1:0]                           taps_eff;
	logic [FILL_W-1:0]                          prior;
	logic [TAP_W-1:0]                           prior_p1;
	logic                                       produce;
	logic                                       advance;
	logic                                       accept;
	logic                                       vld_s1;

	logic [COEF_IDX_W-1:0]                      coef_idx [MAX_TAPS];
	coef_t                                      coef_sel [MAX_TAPS];
	sample_t                                    x_in     [MAX_TAPS];
	sample_t                                    x_hold   [MAX_TAPS];
	prod_t                                      prod_s1  [MAX_TAPS];

	stage_ctl_t                                 tree_ctl;
	acc_t                                       sum_s5;
	logic                                       vld_s5;
	quot_t                                      quot;
	logic                                       sat;

	logic                                       out_valid_q;
	sample_t                                    filtered_q;
	logic                                       clipped_q;

	// Decode the configuration access
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:CFG_ADDR_W-REG_IDX_W]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q  <= TAP_RESET;
			coef_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_NTAPS:  tap_q     <= pwdata[TAP_W-1:0];
				REG_COEF_0: coef_q[0] <= pwdata;
				REG_COEF_1: coef_q[1] <= pwdata;
				REG_COEF_2: coef_q[2] <= pwdata;
				REG_COEF_3: coef_q[3] <= pwdata;
				default: ;
			endcase
		end
	end

	// Read back configuration registers
	always_comb begin
		unique case (reg_idx)
			REG_NTAPS:  prdata = CFG_DATA_W'(tap_q);
			REG_COEF_0: prdata = coef_q[0];
			REG_COEF_1: prdata = coef_q[1];
			REG_COEF_2: prdata = coef_q[2];
			REG_COEF_3: prdata = coef_q[3];
			default:    prdata = '0;
		endcase
	end

	// Clamp the tap count into its usable range
	always_comb begin
		if (tap_q == '0) begin
			taps_eff = TAP_W'(1);
		end else if (tap_q > TAP_W'(MAX_TAPS)) begin
			taps_eff = TAP_W'(MAX_TAPS);
		end else begin
			taps_eff = tap_q;
		end
	end

	// Handshake: the whole pipeline holds while a result waits
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// Track how far the current block has filled the window
	assign prior    = block_start ? '0 : fill_q;
	assign prior_p1 = TAP_W'(prior) + TAP_W'(1);
	assign produce  = prior_p1 >= taps_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= (prior_p1 > TAP_W'(FILL_MAX)) ? FILL_MAX : prior_p1[FILL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (advance) begin
			vld_s1 <= accept && produce;
		end
	end

	// Align coefficients: the newest sample meets the last active coefficient
	always_comb begin
		for (int j = 0; j < MAX_TAPS; j++) begin
			coef_idx[j] = COEF_IDX_W'(taps_eff - TAP_W'(j) - TAP_W'(1));
			if (TAP_W'(j) < taps_eff) begin
				coef_sel[j] = coef_t'(coef_q[coef_idx[j][COEF_IDX_W-1:2]]
					[coef_idx[j][1:0]*COEF_W +: COEF_W]);
			end else begin
				coef_sel[j] = '0;
			end
		end
	end

	// Chain of tap cells, cell j sees the sample of age j
	always_comb begin
		x_in[0] = sample_in;
		for (int j = 1; j < MAX_TAPS; j++) begin
			x_in[j] = x_hold[j-1];
		end
	end

	for (genvar j = 0; j < MAX_TAPS; j++) begin : g_tap
		firq_tap_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift_en (accept),
			.x_in     (x_in[j]),
			.coef     (coef_sel[j]),
			.x_q      (x_hold[j]),
			.prod_s1  (prod_s1[j])
		);
	end

	// Sum the products
	assign tree_ctl = '{en: advance, vld: vld_s1};

	firq_sum_tree u_tree (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_s1  (tree_ctl),
		.prod_s1 (prod_s1),
		.sum_s5  (sum_s5),
		.vld_s5  (vld_s5)
	);

	// Drop the fraction bits and saturate to 16 bits
	assign quot = sum_s5[ACC_W-1:Q_SHIFT];
	assign sat  = !((&quot[QUOT_W-1:SAMPLE_W-1]) || !(|quot[QUOT_W-1:SAMPLE_W-1]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && vld_s5) begin
			if (sat) begin
				filtered_q <= quot[QUOT_W-1] ? SAT_MIN : SAT_MAX;
			end else begin
				filtered_q <= quot[SAMPLE_W-1:0];
			end
			clipped_q <= sat;
		end
	end

	assign out_valid = out_valid_q;
	assign filtered  = filtered_q;
	assign clipped   = clipped_q;

	// Checks
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_MAX)
		else $error("fill level beyond the delay line depth");

	a_block_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && block_start |=> fill_q == FILL_W'(1))
		else $error("block start did not restart the window");

	a_clip_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> (filtered == SAT_MAX) || (filtered == SAT_MIN))
		else $error("clipped result is not a saturation value");

	a_full_window: assert property (@(posedge clk) disable iff (!arst_n)
		accept && produce |=> vld_s1)
		else $error("full window did not launch a result");

endmodule

`default_nettype wire
